### rtl/cpa_pkg.sv
// Shared types and constants for the complex power accumulator.
// Used by cpa_position, cpa_ram users and complex_power_accumulator; no dependencies.
package cpa_pkg;

    localparam int MAX_ANTENNAS = 16;
    localparam int MAX_CHANNELS = 128;
    localparam int MAX_FRAMES   = 256;
    localparam int MAX_PACKETS  = 1024;
    localparam int TOTAL_WIDTH  = 40;

    // Position widths
    localparam int ANT_W   = $clog2(MAX_ANTENNAS);
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int PKT_W   = $clog2(MAX_PACKETS);

    // Count register widths (hold the maximum itself)
    localparam int ANT_CNT_W   = $clog2(MAX_ANTENNAS + 1);
    localparam int CH_CNT_W    = $clog2(MAX_CHANNELS + 1);
    localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int PKT_CNT_W   = $clog2(MAX_PACKETS + 1);

    localparam int CFG_DATA_W = PKT_CNT_W;
    localparam int CFG_IDX_W  = 2;

    localparam int BIN_DEPTH = MAX_ANTENNAS * MAX_CHANNELS;
    localparam int ADDR_W    = ANT_W + CH_W;

    // (2re+1)^2 + (2im+1)^2 peaks at 2 * 255^2
    localparam int SAMPLE_W = 8;
    localparam int SQ_W     = 16;
    localparam int POWER_W  = SQ_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANTENNA_COUNT = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_FRAMES_PER_PACKET = 2'd2,
        CFG_PACKETS_PER_INTEGRATION = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ANT_W-1:0] antenna;
        logic [CH_W-1:0]  channel;
        logic             dump;
        logic             last;
    } pos_t;

endpackage

### rtl/cpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // Read-first: a read at the written address returns the old word
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cpa_position.sv
// Configuration registers and the antenna/channel/frame/packet position counters.
// Depends on cpa_pkg.
module cpa_position (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          advance,
    output cpa_pkg::pos_t                 pos
);
    import cpa_pkg::*;

    logic [ANT_CNT_W-1:0]   ant_cnt_reg;
    logic [CH_CNT_W-1:0]    ch_cnt_reg;
    logic [FRAME_CNT_W-1:0] frame_cnt_reg;
    logic [PKT_CNT_W-1:0]   pkt_cnt_reg;

    logic [ANT_CNT_W-1:0]   na;
    logic [CH_CNT_W-1:0]    nc;
    logic [FRAME_CNT_W-1:0] nf;
    logic [PKT_CNT_W-1:0]   np;

    logic [ANT_W-1:0]   ant_pos_reg, ant_pos_next;
    logic [CH_W-1:0]    ch_pos_reg, ch_pos_next;
    logic [FRAME_W-1:0] frame_pos_reg, frame_pos_next;
    logic [PKT_W-1:0]   pkt_pos_reg, pkt_pos_next;

    logic wrap_ant, wrap_ch, wrap_frame, wrap_pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ant_cnt_reg   <= ANT_CNT_W'(MAX_ANTENNAS);
            ch_cnt_reg    <= CH_CNT_W'(MAX_CHANNELS);
            frame_cnt_reg <= FRAME_CNT_W'(1);
            pkt_cnt_reg   <= PKT_CNT_W'(128);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ANTENNA_COUNT:           ant_cnt_reg   <= cfg_data[ANT_CNT_W-1:0];
                CFG_CHANNEL_COUNT:           ch_cnt_reg    <= cfg_data[CH_CNT_W-1:0];
                CFG_FRAMES_PER_PACKET:       frame_cnt_reg <= cfg_data[FRAME_CNT_W-1:0];
                CFG_PACKETS_PER_INTEGRATION: pkt_cnt_reg   <= cfg_data[PKT_CNT_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (ant_cnt_reg == '0)
            na = ANT_CNT_W'(1);
        else if (ant_cnt_reg > ANT_CNT_W'(MAX_ANTENNAS))
            na = ANT_CNT_W'(MAX_ANTENNAS);
        else
            na = ant_cnt_reg;

        if (ch_cnt_reg == '0)
            nc = CH_CNT_W'(1);
        else if (ch_cnt_reg > CH_CNT_W'(MAX_CHANNELS))
            nc = CH_CNT_W'(MAX_CHANNELS);
        else
            nc = ch_cnt_reg;

        if (frame_cnt_reg == '0)
            nf = FRAME_CNT_W'(1);
        else if (frame_cnt_reg > FRAME_CNT_W'(MAX_FRAMES))
            nf = FRAME_CNT_W'(MAX_FRAMES);
        else
            nf = frame_cnt_reg;

        if (pkt_cnt_reg == '0)
            np = PKT_CNT_W'(1);
        else if (pkt_cnt_reg > PKT_CNT_W'(MAX_PACKETS))
            np = PKT_CNT_W'(MAX_PACKETS);
        else
            np = pkt_cnt_reg;
    end

    // A position at or past its count minus one wraps on the next advance
    assign wrap_ant   = (ANT_CNT_W'(ant_pos_reg) + ANT_CNT_W'(1)) >= na;
    assign wrap_ch    = (CH_CNT_W'(ch_pos_reg) + CH_CNT_W'(1)) >= nc;
    assign wrap_frame = (FRAME_CNT_W'(frame_pos_reg) + FRAME_CNT_W'(1)) >= nf;
    assign wrap_pkt   = (PKT_CNT_W'(pkt_pos_reg) + PKT_CNT_W'(1)) >= np;

    always_comb
    begin
        ant_pos_next   = ant_pos_reg;
        ch_pos_next    = ch_pos_reg;
        frame_pos_next = frame_pos_reg;
        pkt_pos_next   = pkt_pos_reg;
        if (advance)
        begin
            if (!wrap_ant)
                ant_pos_next = ant_pos_reg + ANT_W'(1);
            else
            begin
                ant_pos_next = '0;
                if (!wrap_ch)
                    ch_pos_next = ch_pos_reg + CH_W'(1);
                else
                begin
                    ch_pos_next = '0;
                    if (!wrap_frame)
                        frame_pos_next = frame_pos_reg + FRAME_W'(1);
                    else
                    begin
                        frame_pos_next = '0;
                        pkt_pos_next   = wrap_pkt ? '0 : pkt_pos_reg + PKT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ant_pos_reg   <= '0;
            ch_pos_reg    <= '0;
            frame_pos_reg <= '0;
            pkt_pos_reg   <= '0;
        end
        else
        begin
            ant_pos_reg   <= ant_pos_next;
            ch_pos_reg    <= ch_pos_next;
            frame_pos_reg <= frame_pos_next;
            pkt_pos_reg   <= pkt_pos_next;
        end
    end

    always_comb
    begin
        pos.antenna = ant_pos_reg;
        pos.channel = ch_pos_reg;
        pos.dump    = wrap_frame && wrap_pkt;
        pos.last    = wrap_frame && wrap_pkt && wrap_ant && wrap_ch;
    end

endmodule

### rtl/complex_power_accumulator.sv
// Complex power accumulator: integrates (2re+1)^2 + (2im+1)^2 per antenna/channel bin.
// Depends on cpa_pkg, cpa_position and cpa_ram.

// Takes one signed 8-bit complex sample per cycle when in_ready is high, in packet
// order (antenna fastest, then channel, then frame) and adds four times its offset
// power to a 40-bit bin total held in a 2048 x 40 RAM. A transaction passes through
// the accept stage, where the bin is read and the power is squared, and the update
// stage, where the saturating add is written back; a bypass register covers a bin
// read in the same cycle it is written, so back-to-back samples to one bin are exact.
// Throughput is one sample per cycle unless the clearing sweep runs or a dump waits
// on a stalled output; a dump total enters the output register as it leaves the
// update stage. During the last frame of the last packet of an integration each bin
// is emitted and cleared; last_bin marks the final one. After reset the block sweeps
// the RAM to zero, one bin per cycle, with in_ready low; configuration writes are
// taken during that time and should be made only while the block is idle.
module complex_power_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [cpa_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [cpa_pkg::SAMPLE_W-1:0] sample_imag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cpa_pkg::ANT_W-1:0]        antenna_index,
    output logic [cpa_pkg::CH_W-1:0]         channel_index,
    output logic [cpa_pkg::TOTAL_WIDTH-1:0]  power_total,
    output logic                             last_bin
);
    import cpa_pkg::*;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    pos_t pos;
    logic accept;

    // Clearing sweep
    logic              clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // Update stage
    logic               s1_valid_reg, s1_valid_next;
    pos_t               s1_pos_reg;
    logic [POWER_W-1:0] s1_power_reg;
    logic               s1_adv;
    logic [ADDR_W-1:0]  s1_addr;

    // Bypass of the most recent bin write
    logic                   byp_valid_reg;
    logic [ADDR_W-1:0]      byp_addr_reg;
    logic [TOTAL_WIDTH-1:0] byp_data_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [ANT_W-1:0]       out_ant_reg;
    logic [CH_W-1:0]        out_ch_reg;
    logic [TOTAL_WIDTH-1:0] out_total_reg;
    logic                   out_last_reg;
    logic                   out_can_load;
    logic                   out_load;

    logic signed [SAMPLE_W:0]     re2, im2;
    logic signed [2*SAMPLE_W+1:0] re_sq, im_sq;
    logic [POWER_W-1:0]           power;

    logic [TOTAL_WIDTH-1:0] rd_data;
    logic [TOTAL_WIDTH-1:0] stored;
    logic [TOTAL_WIDTH:0]   sum;
    logic [TOTAL_WIDTH-1:0] total;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [TOTAL_WIDTH-1:0] ram_wdata;

    cpa_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    cpa_ram #(
        .WIDTH (TOTAL_WIDTH),
        .DEPTH (BIN_DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr ({pos.antenna, pos.channel}),
        .rdata (rd_data)
    );

    // Handshake
    assign out_can_load = !out_valid_reg || out_ready;
    assign s1_adv       = s1_valid_reg && (!s1_pos_reg.dump || out_can_load);
    assign in_ready     = !clear_active_reg && (!s1_valid_reg || s1_adv);
    assign accept       = in_valid && in_ready;
    assign out_load     = s1_adv && s1_pos_reg.dump;

    // 2x+1 is the sample with a one appended
    assign re2   = {sample_real, 1'b1};
    assign im2   = {sample_imag, 1'b1};
    assign re_sq = re2 * re2;
    assign im_sq = im2 * im2;
    assign power = POWER_W'(re_sq[SQ_W-1:0]) + POWER_W'(im_sq[SQ_W-1:0]);

    // Saturating add on the bin total
    assign s1_addr = {s1_pos_reg.antenna, s1_pos_reg.channel};
    assign stored  = (byp_valid_reg && byp_addr_reg == s1_addr) ? byp_data_reg : rd_data;
    assign sum     = {1'b0, stored} + (TOTAL_WIDTH + 1)'(s1_power_reg);
    assign total   = sum[TOTAL_WIDTH] ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];

    always_comb
    begin
        if (clear_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_adv;
            ram_waddr = s1_addr;
            ram_wdata = s1_pos_reg.dump ? '0 : total;
        end
    end

    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(BIN_DEPTH - 1))
                clear_active_next = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            byp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            if (s1_adv)
                byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos;
            s1_power_reg <= power;
        end
        if (s1_adv)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= ram_wdata;
        end
        if (out_load)
        begin
            out_ant_reg   <= s1_pos_reg.antenna;
            out_ch_reg    <= s1_pos_reg.channel;
            out_total_reg <= total;
            out_last_reg  <= s1_pos_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign antenna_index = out_ant_reg;
    assign channel_index = out_ch_reg;
    assign power_total   = out_total_reg;
    assign last_bin      = out_last_reg;

    // No sample may enter while the sweep still owns the write port
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !in_ready)
        else $error("sample accepted during clearing sweep");

    a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !clear_active_reg)
        else $error("update stage busy during clearing sweep");

    // A held update-stage transaction keeps its bin
    a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_pos_reg))
        else $error("update stage dropped a transaction");

    // Every new result comes from a dump transaction
    a_result_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> s1_pos_reg.dump && out_can_load)
        else $error("result loaded without a dump or over a pending result");

    // A bin dumped at the previous edge is read back as zero through the bypass
    a_dump_clears_bin: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> byp_valid_reg && byp_data_reg == '0)
        else $error("dumped bin not cleared");

endmodule
